// File: rtl/stli_pkg.sv
// shared widths, codes and types of the sorted-table linear interpolator
`timescale 1ns / 1ps

package stli_pkg;

    localparam int IDX_W      = 10;
    localparam int PT_W       = 32;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 11;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 32;
    localparam int REGION_W   = 2;

    // product and quotient widths of the interpolation divide
    localparam int PROD_W     = 64;
    localparam int QUOT_W     = 33;
    localparam int QSAT_W     = 34;

    localparam logic [CFG_W-1:0] CFG_LEN_RESET = 11'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [REGION_W-1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_FIRST    = 2'd1,
        REGION_LAST     = 2'd2
    } region_t;

endpackage

// File: rtl/stli_table_mem.sv
// breakpoint and value storage: one write port, one registered read port
`timescale 1ns / 1ps

module stli_table_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [stli_pkg::PT_W-1:0]      wr_point,
    input  logic [stli_pkg::VAL_W-1:0]     wr_value,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [stli_pkg::PT_W-1:0]      rd_point,
    output logic [stli_pkg::VAL_W-1:0]     rd_value
);

    logic [stli_pkg::PT_W-1:0]  point_mem [DEPTH];
    logic [stli_pkg::VAL_W-1:0] value_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[wr_addr] <= wr_point;
            value_mem[wr_addr] <= wr_value;
        end
        rd_point <= point_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

// File: rtl/stli_divider.sv
// restoring divider, one quotient bit per cycle, quotient saturated at 2^33
`timescale 1ns / 1ps

module stli_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stli_pkg::PROD_W-1:0]   dividend,
    input  logic [stli_pkg::PT_W-1:0]     divisor,
    output logic                          done,
    output logic [stli_pkg::QSAT_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(stli_pkg::QUOT_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          sat_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [stli_pkg::PT_W-1:0]     rem_reg;
    logic [stli_pkg::PT_W-1:0]     rem_next;
    logic [stli_pkg::QUOT_W-1:0]   dq_reg;
    logic [stli_pkg::PT_W-1:0]     div_reg;
    logic [stli_pkg::PT_W:0]       trial;
    logic [stli_pkg::PT_W:0]       trial_diff;
    logic                          trial_ge;
    logic                          start_sat;

    // upper bits at or above the divisor: quotient is at least 2^33
    assign start_sat = {1'b0, dividend[stli_pkg::PROD_W-1:stli_pkg::QUOT_W]} >= divisor;

    assign trial      = {rem_reg, dq_reg[stli_pkg::QUOT_W-1]};
    assign trial_ge   = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};
    assign rem_next   = trial_ge ? trial_diff[stli_pkg::PT_W-1:0] : trial[stli_pkg::PT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                sat_reg <= start_sat;
                if (start_sat)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(stli_pkg::QUOT_W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[stli_pkg::PROD_W-1:stli_pkg::QUOT_W]};
            dq_reg  <= dividend[stli_pkg::QUOT_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[stli_pkg::QUOT_W-2:0], trial_ge};
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? {1'b1, {stli_pkg::QUOT_W{1'b0}}} : {1'b0, dq_reg};

endmodule

// File: rtl/sorted_table_linear_interpolator_top.sv
// top level of the sorted-table linear interpolator
`timescale 1ns / 1ps

// usage:
//   s_* carries requests; s_tuser is the op (0 write entry, 1 query).
//   a write stores point/entry_value at entry_index, no result.
//   a query returns one result on m_*: m_tdata the interpolated value,
//   m_tuser the region (0 interior, 1 clamped to first, 2 clamped to last).
//   cfg_* writes table_length (clamped to 2..TABLE_DEPTH); always ready,
//   write it only while no query is in flight.
// steps of a query, one query at a time:
//   read the end entries and check the clamps; then, unless clamped, the
//   binary search steps (about ceil(log2(n+1)) of them) and, for an
//   interior point, two reads, a subtract, a multiply and the bit-serial
//   divider; then the output.
//   the search reads the single table memory port once per step, and the
//   divider produces one quotient bit per cycle.
// reset clears control state and sets table_length to 2; table contents
//   are undefined until written, no clearing pass.
// a finished result sits in the output register while the next request is
//   taken; a query finishing into a stalled output waits there.

module sorted_table_linear_interpolator_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[9:0], point[41:10], entry_value[73:42], zero fill
    input  logic [stli_pkg::IN_DATA_W-1:0]    s_tdata,
    // op[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // interp_value[31:0]
    output logic [stli_pkg::OUT_DATA_W-1:0]   m_tdata,
    // region[1:0]
    output logic [stli_pkg::REGION_W-1:0]     m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stli_pkg::CFG_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIFF,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                              state_reg;
    logic [stli_pkg::CFG_W-1:0]          cfg_reg;
    logic [LEN_W-1:0]                    n_reg;
    logic [LEN_W-1:0]                    lo_reg;
    logic [LEN_W-1:0]                    hi_reg;
    logic [LEN_W-1:0]                    mid_reg;
    logic [stli_pkg::PT_W-1:0]           p_reg;
    logic [stli_pkg::PT_W-1:0]           e_first_reg;
    logic [stli_pkg::VAL_W-1:0]          v_first_reg;
    logic [stli_pkg::VAL_W-1:0]          v_last_reg;
    logic [stli_pkg::PT_W-1:0]           e0_reg;
    logic [stli_pkg::VAL_W-1:0]          v0_reg;
    logic [stli_pkg::PT_W-1:0]           mde_reg;
    logic [stli_pkg::PT_W-1:0]           mdx_reg;
    logic [stli_pkg::PT_W-1:0]           mdv_reg;
    logic                                neg_reg;
    logic [stli_pkg::PROD_W-1:0]         prod_reg;
    logic [stli_pkg::VAL_W-1:0]          res_reg;
    stli_pkg::region_t                   region_reg;
    logic                                m_tvalid_reg;
    logic [stli_pkg::OUT_DATA_W-1:0]     m_tdata_reg;
    stli_pkg::region_t                   m_tuser_reg;

    logic                                s_accept;
    logic [stli_pkg::IDX_W-1:0]          in_index;
    logic [stli_pkg::PT_W-1:0]           in_point;
    logic [stli_pkg::VAL_W-1:0]          in_value;
    logic [31:0]                         in_index32;
    logic [31:0]                         n32;
    logic [LEN_W-1:0]                    n_cur;
    logic [LEN_W-1:0]                    n_m1;
    logic [LEN_W-1:0]                    lo_m1;
    logic [LEN_W-1:0]                    mid;
    logic                                wr_en;
    logic [ADDR_W-1:0]                   wr_addr;
    logic [ADDR_W-1:0]                   rd_addr;
    logic [stli_pkg::PT_W-1:0]           rd_point;
    logic [stli_pkg::VAL_W-1:0]          rd_value;
    logic [stli_pkg::PT_W:0]             de;
    logic [stli_pkg::PT_W:0]             dx;
    logic [stli_pkg::VAL_W:0]            dv;
    logic [stli_pkg::PT_W:0]             mde_w;
    logic [stli_pkg::PT_W:0]             mdx_w;
    logic [stli_pkg::VAL_W:0]            mdv_w;
    logic                                neg_w;
    logic                                div_start;
    logic                                div_done;
    logic [stli_pkg::QSAT_W-1:0]         div_quot;
    logic signed [34:0]                  v0_ext;
    logic signed [34:0]                  mq_ext;
    logic signed [34:0]                  r_sum;
    logic [stli_pkg::VAL_W-1:0]          r_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_index = s_tdata[stli_pkg::IDX_W-1:0];
    assign in_point = s_tdata[stli_pkg::IDX_W +: stli_pkg::PT_W];
    assign in_value = s_tdata[stli_pkg::IDX_W + stli_pkg::PT_W +: stli_pkg::VAL_W];

    // writes beyond the table are dropped
    assign in_index32 = 32'(in_index);
    assign wr_en      = s_accept && (s_tuser == stli_pkg::OP_WRITE)
                        && (in_index32 < 32'(TABLE_DEPTH));
    assign wr_addr    = in_index32[ADDR_W-1:0];

    // length in use, clamped to 2..TABLE_DEPTH
    always_comb
    begin
        priority if (32'(cfg_reg) < 32'd2)
            n32 = 32'd2;
        else if (32'(cfg_reg) > 32'(TABLE_DEPTH))
            n32 = 32'(TABLE_DEPTH);
        else
            n32 = 32'(cfg_reg);
    end
    assign n_cur = n32[LEN_W-1:0];

    assign n_m1  = n_reg - LEN_W'(1);
    assign lo_m1 = lo_reg - LEN_W'(1);
    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        unique case (state_reg)
            ST_RD_LAST: rd_addr = n_m1[ADDR_W-1:0];
            ST_SRCH_RD: rd_addr = mid[ADDR_W-1:0];
            ST_RD_LO:   rd_addr = lo_m1[ADDR_W-1:0];
            ST_RD_HI:   rd_addr = lo_reg[ADDR_W-1:0];
            default:    rd_addr = '0;
        endcase
    end

    stli_table_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_point (in_point),
        .wr_value (in_value),
        .rd_addr  (rd_addr),
        .rd_point (rd_point),
        .rd_value (rd_value)
    );

    // differences from the lower bracket entry, with the upper entry arriving from memory
    assign de    = {1'b0, rd_point} - {1'b0, e0_reg};
    assign dx    = {1'b0, p_reg} - {1'b0, e0_reg};
    assign dv    = {rd_value[stli_pkg::VAL_W-1], rd_value} - {v0_reg[stli_pkg::VAL_W-1], v0_reg};
    assign mde_w = de[stli_pkg::PT_W] ? -de : de;
    assign mdx_w = dx[stli_pkg::PT_W] ? -dx : dx;
    assign mdv_w = dv[stli_pkg::VAL_W] ? -dv : dv;
    assign neg_w = (de[stli_pkg::PT_W] ^ dx[stli_pkg::PT_W] ^ dv[stli_pkg::VAL_W])
                   && (dx != '0) && (dv != '0);

    assign div_start = (state_reg == ST_DIV_START);

    stli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mde_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // v0 plus or minus the quotient, saturated to 32 bits
    assign v0_ext = 35'(signed'(v0_reg));
    assign mq_ext = signed'({1'b0, div_quot});
    assign r_sum  = neg_reg ? (v0_ext - mq_ext) : (v0_ext + mq_ext);
    always_comb
    begin
        if (r_sum[34:31] == 4'b0000 || r_sum[34:31] == 4'b1111)
            r_sat = r_sum[stli_pkg::VAL_W-1:0];
        else if (r_sum[34])
            r_sat = {1'b1, {(stli_pkg::VAL_W-1){1'b0}}};
        else
            r_sat = {1'b0, {(stli_pkg::VAL_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= stli_pkg::CFG_LEN_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept && (s_tuser == stli_pkg::OP_QUERY))
                        state_reg <= ST_RD_FIRST;
                end
                ST_RD_FIRST:
                    state_reg <= ST_RD_LAST;
                ST_RD_LAST:
                    state_reg <= ST_CHK_LAST;
                ST_CHK_LAST:
                begin
                    priority if (p_reg <= e_first_reg)
                    begin
                        res_reg    <= v_first_reg;
                        region_reg <= stli_pkg::REGION_FIRST;
                        state_reg  <= ST_OUT;
                    end
                    else if (p_reg >= rd_point)
                    begin
                        res_reg    <= rd_value;
                        region_reg <= stli_pkg::REGION_LAST;
                        state_reg  <= ST_OUT;
                    end
                    else
                        state_reg <= ST_SRCH_RD;
                end
                ST_SRCH_RD:
                begin
                    priority if (lo_reg < hi_reg)
                        state_reg <= ST_SRCH_CMP;
                    else if (lo_reg == '0)
                    begin
                        res_reg    <= v_first_reg;
                        region_reg <= stli_pkg::REGION_FIRST;
                        state_reg  <= ST_OUT;
                    end
                    else if (lo_reg >= n_reg)
                    begin
                        res_reg    <= v_last_reg;
                        region_reg <= stli_pkg::REGION_LAST;
                        state_reg  <= ST_OUT;
                    end
                    else
                        state_reg <= ST_RD_LO;
                end
                ST_SRCH_CMP:
                    state_reg <= ST_SRCH_RD;
                ST_RD_LO:
                    state_reg <= ST_RD_HI;
                ST_RD_HI:
                    state_reg <= ST_DIFF;
                ST_DIFF:
                begin
                    region_reg <= stli_pkg::REGION_INTERIOR;
                    // equal bracketing points give the lower value
                    if (de == '0)
                    begin
                        res_reg   <= v0_reg;
                        state_reg <= ST_OUT;
                    end
                    else
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                    state_reg <= ST_DIV_START;
                ST_DIV_START:
                    state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= r_sat;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        m_tuser_reg  <= region_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p_reg  <= in_point;
            n_reg  <= n_cur;
            lo_reg <= '0;
            hi_reg <= n_cur;
        end
        if (state_reg == ST_RD_LAST)
        begin
            e_first_reg <= rd_point;
            v_first_reg <= rd_value;
        end
        if (state_reg == ST_CHK_LAST)
            v_last_reg <= rd_value;
        if (state_reg == ST_SRCH_RD)
            mid_reg <= mid;
        if (state_reg == ST_SRCH_CMP)
        begin
            if (rd_point < p_reg)
                lo_reg <= mid_reg + LEN_W'(1);
            else
                hi_reg <= mid_reg;
        end
        if (state_reg == ST_RD_HI)
        begin
            e0_reg <= rd_point;
            v0_reg <= rd_value;
        end
        if (state_reg == ST_DIFF)
        begin
            mde_reg <= mde_w[stli_pkg::PT_W-1:0];
            mdx_reg <= mdx_w[stli_pkg::PT_W-1:0];
            mdv_reg <= mdv_w[stli_pkg::VAL_W-1:0];
            neg_reg <= neg_w;
        end
        if (state_reg == ST_MUL)
            prod_reg <= mdv_reg * mdx_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide wait");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRCH_RD |-> lo_reg <= hi_reg && hi_reg <= n_reg)
        else $error("search bounds out of order");

    a_bracket_interior: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_LO |-> lo_reg != '0 && lo_reg < n_reg)
        else $error("bracket index outside the table");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && m_tvalid_reg && !m_tready |=> state_reg == ST_OUT)
        else $error("pending result overwritten");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined region on output");
`endif

endmodule

// File: verif/stli_result_checker.sv
// result checker for the interpolator: follows the table and length, predicts each query
`timescale 1ns / 1ps

module stli_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // entry_index[9:0], point[41:10], entry_value[73:42], zero fill
    input  logic [stli_pkg::IN_DATA_W-1:0]   s_tdata,
    // op[0]
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // interp_value[31:0]
    input  logic [stli_pkg::OUT_DATA_W-1:0]  m_tdata,
    // region[1:0]
    input  logic [stli_pkg::REGION_W-1:0]    m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [stli_pkg::CFG_W-1:0]       cfg_data,
    output int                               mismatches,
    output int                               outstanding
);

    import stli_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        region_t          zone;
    } answer_t;

    logic [PT_W-1:0]  point_tab [DEPTH];
    logic [VAL_W-1:0] value_tab [DEPTH];
    logic [CFG_W-1:0] length_reg;
    answer_t          answers_due [$];
    int               fails;

    function automatic answer_t interpolated_answer(input logic [PT_W-1:0] p);
        int          n;
        int          lo;
        int          hi;
        int          mid;
        longint      pl;
        longint      e0;
        longint      e1;
        longint      v0;
        longint      v1;
        longint      de;
        longint      dx;
        longint      dv;
        longint      r;
        logic [63:0] mde;
        logic [63:0] mdx;
        logic [63:0] mdv;
        logic [63:0] mq;
        bit          neg;
        answer_t     a;
        n = (length_reg < 2) ? 2 : ((length_reg > DEPTH) ? DEPTH : int'(length_reg));
        if (p <= point_tab[0])
        begin
            a.value = value_tab[0];
            a.zone  = REGION_FIRST;
        end
        else if (p >= point_tab[n-1])
        begin
            a.value = value_tab[n-1];
            a.zone  = REGION_LAST;
        end
        else
        begin
            // lower-bound search over the used slots
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (point_tab[mid] < p)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo == 0)
            begin
                a.value = value_tab[0];
                a.zone  = REGION_FIRST;
            end
            else if (lo >= n)
            begin
                a.value = value_tab[n-1];
                a.zone  = REGION_LAST;
            end
            else
            begin
                a.zone = REGION_INTERIOR;
                pl = p;
                e0 = point_tab[lo-1];
                e1 = point_tab[lo];
                v0 = signed'(value_tab[lo-1]);
                v1 = signed'(value_tab[lo]);
                de = e1 - e0;
                dx = pl - e0;
                dv = v1 - v0;
                if (de == 0)
                    a.value = value_tab[lo-1];
                else
                begin
                    mde = (de < 0) ? -de : de;
                    mdx = (dx < 0) ? -dx : dx;
                    mdv = (dv < 0) ? -dv : dv;
                    neg = ((de < 0) != (dx < 0)) != (dv < 0);
                    if (mdx == 0 || mdv == 0)
                        neg = 0;
                    // magnitude quotient truncates, so the sign applies after it
                    mq = (mdv * mdx) / mde;
                    if (mq > 64'h2_0000_0000)
                        mq = 64'h2_0000_0000;
                    r = neg ? v0 - longint'(mq) : v0 + longint'(mq);
                    if (r > 64'sd2147483647)
                        r = 64'sd2147483647;
                    if (r < -64'sd2147483648)
                        r = -64'sd2147483648;
                    a.value = r[31:0];
                end
            end
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            length_reg = CFG_LEN_RESET;
            answers_due.delete();
            fails = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results first, so a request taken on the same edge cannot be matched early
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with none expected, got value %h region %0d",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.value !== m_tdata)
                    begin
                        fails++;
                        $display("%0t: interp_value expected %h got %h",
                                 $time, want.value, m_tdata);
                    end
                    if (want.zone !== m_tuser)
                    begin
                        fails++;
                        $display("%0t: region expected %0d got %0d",
                                 $time, want.zone, m_tuser);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                length_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_WRITE)
                begin
                    point_tab[s_tdata[9:0]] = s_tdata[41:10];
                    value_tab[s_tdata[9:0]] = s_tdata[73:42];
                end
                else
                    answers_due.push_back(interpolated_answer(s_tdata[41:10]));
            end
            mismatches  <= fails;
            outstanding <= answers_due.size();
        end
    end

endmodule

// File: verif/tb.sv
// testbench top for the interpolator: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb;

    import stli_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int RUN_LIMIT   = 1_000_000;
    localparam int WRITE_QUIET = 4;
    localparam int QUERY_QUIET = 100;
    localparam int ITEM_GOAL   = 450;
    localparam int CALM_AFTER  = 380;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [REGION_W-1:0]    m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;

    int mismatches;
    int outstanding;
    int cycles     = 0;
    int stall_left = 0;
    int gap_odds   = 4;
    bit calm       = 0;

    // points currently loaded, used to aim the queries and to rewrite values on loaded points
    logic [PT_W-1:0] loaded_pts [DEPTH];

    always #5 clk = ~clk;

    sorted_table_linear_interpolator_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stli_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1;
    endfunction

    // output stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                m_tready <= 1'b1;
        end
        else if (rst_n && take_break())
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 13);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic [PT_W-1:0] pt, input logic [VAL_W-1:0] val);
        if (take_break())
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, val, pt, idx};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_query(input logic [PT_W-1:0] pt);
        send_request(OP_QUERY, IDX_W'($urandom_range(0, DEPTH-1)), pt, $urandom());
    endtask

    // stop sending and wait until every query has answered
    task automatic settle(input int quiet);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (quiet) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_table(input int n);
        int              style;
        logic [PT_W-1:0] lo_pt;
        logic [PT_W-1:0] hi_pt;
        logic [PT_W-1:0] pt;
        logic [PT_W-1:0] max_step;
        logic [PT_W-1:0] step;
        logic [VAL_W-1:0] val;
        style = $urandom_range(0, 3);
        lo_pt = $urandom();
        hi_pt = $urandom();
        if (lo_pt > hi_pt)
        begin
            pt    = lo_pt;
            lo_pt = hi_pt;
            hi_pt = pt;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            lo_pt = 32'h0000_0000;
            hi_pt = 32'hFFFF_FFFF;
        end
        max_step = (hi_pt - lo_pt) / (n - 1);
        if (max_step == 0)
            max_step = 1;
        pt = lo_pt;
        for (int k = 0; k < n; k++)
        begin
            if (style == 3)
                pt = $urandom();
            loaded_pts[k] = pt;
            if ($urandom_range(0, 3) == 0)
                val = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
            else
                val = $urandom();
            send_request(OP_WRITE, IDX_W'(k), pt, val);
            // style 2 repeats points now and then
            if (style == 2 && $urandom_range(0, 3) == 0)
                step = 0;
            else
                step = $urandom_range(1, max_step);
            if (pt > 32'hFFFF_FFFF - step)
                step = 0;
            pt = pt + step;
        end
    endtask

    function automatic logic [PT_W-1:0] aim_point(input int n);
        int              k;
        logic [PT_W-1:0] a;
        logic [PT_W-1:0] b;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, loaded_pts[0]);
            1: return $urandom_range(loaded_pts[n-1], 32'hFFFF_FFFF);
            2, 3: return loaded_pts[k];
            4: return loaded_pts[k] + 1;
            5: return loaded_pts[k] - 1;
            6: return $urandom();
            default:
            begin
                if (k > n - 2)
                    k = n - 2;
                a = loaded_pts[k];
                b = loaded_pts[k+1];
                return (a <= b) ? $urandom_range(a, b) : $urandom_range(b, a);
            end
        endcase
    endfunction

    initial
    begin
        int               phase;
        int               n;
        int               queries;
        int               k;
        int               random_items;
        logic [CFG_W-1:0] len;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WRITE;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-range two-point table at the reset length
        send_request(OP_WRITE, 10'd0, 32'h0000_0000, 32'h8000_0000);
        send_request(OP_WRITE, 10'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_query(32'h0000_0000);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0001);
        send_query(32'hFFFF_FFFE);
        send_query(32'h8000_0000);
        send_query(32'h7FFF_FFFF);
        // falling slope, queries on and around both ends and at the midpoint
        send_request(OP_WRITE, 10'd1, 32'h0001_0000, 32'hFFFF_0000);
        send_request(OP_WRITE, 10'd0, 32'h0000_8000, 32'h0001_0000);
        send_query(32'h0000_0000);
        send_query(32'h0000_8000);
        send_query(32'h0000_8001);
        send_query(32'h0000_C000);
        send_query(32'h0001_0000);
        send_query(32'h0001_0001);
        // out-of-order pair and the top slot
        send_request(OP_WRITE, 10'd0, 32'h0002_0000, 32'h1234_5678);
        send_request(OP_WRITE, 10'd1, 32'h0001_0000, 32'h8765_4321);
        send_request(OP_WRITE, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'h0001_8000);
        send_query(32'h0003_0000);

        phase        = 0;
        random_items = 0;
        while (random_items < ITEM_GOAL)
        begin
            settle(WRITE_QUIET);
            case (phase)
                0: len = 11'd0;
                1: len = 11'd1024;
                2: len = 11'd3;
                3: len = 11'd2047;
                4: len = 11'd1;
                default:
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200)
                                                      : $urandom_range(2, 24);
            endcase
            write_length(len);
            n = (len < 2) ? 2 : ((len > DEPTH) ? DEPTH : int'(len));
            if (!calm)
            begin
                case ($urandom_range(0, 3))
                    0: gap_odds = 0;
                    1: gap_odds = 2;
                    2: gap_odds = 3;
                    default: gap_odds = 6;
                endcase
            end
            load_table(n);
            queries = (n >= 256) ? 30 : $urandom_range(8, 30);
            for (int j = 0; j < queries; j++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // either an unused slot or a new value on a loaded point
                    if (n < DEPTH && $urandom_range(0, 1) == 0)
                        send_request(OP_WRITE, IDX_W'($urandom_range(n, DEPTH-1)),
                                     $urandom(), $urandom());
                    else
                    begin
                        k = $urandom_range(0, n - 1);
                        send_request(OP_WRITE, IDX_W'(k), loaded_pts[k], $urandom());
                    end
                end
                else
                    send_query(aim_point(n));
                random_items++;
                if (random_items >= CALM_AFTER)
                begin
                    calm     = 1;
                    gap_odds = 0;
                end
            end
            phase++;
        end

        settle(QUERY_QUIET);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sorted_table_linear_interpolator_top.f
rtl/stli_pkg.sv
rtl/stli_table_mem.sv
rtl/stli_divider.sv
rtl/sorted_table_linear_interpolator_top.sv
verif/stli_result_checker.sv
verif/tb.sv
